@@ rtl/noise_shaped_dither_requantizer_defines.svh @@
// Assertion macros used by the requantizer checker.
`ifndef NOISE_SHAPED_DITHER_REQUANTIZER_DEFINES_SVH
`define NOISE_SHAPED_DITHER_REQUANTIZER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define NSDR_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define NSDR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nsdr_pkg.sv @@
// Package: widths and generator constants for the dither requantizer.
`timescale 1ns / 1ps

package nsdr_pkg;

	localparam int SAMPLE_W = 32;
	localparam int ERR_W    = 32;
	localparam int PCM_W    = 16;
	localparam int ACC_W    = 36;

	localparam logic [31:0] LCG_MUL = 32'h0019_660d;
	localparam logic [31:0] LCG_ADD = 32'h3c6e_f35f;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ERR_W-1:0]    err_t;
	typedef logic signed [PCM_W-1:0]    pcm_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

@@ rtl/noise_shaped_dither_requantizer.sv @@
// Top level: noise-shaped, dithered requantizer to signed 16-bit PCM.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one request per sample:
//   a signed fixed-point sample with FRACTION_BITS fraction bits and a
//   frame_start flag that zeroes the shaping errors and the dither
//   generator before that sample is processed.
//   Output channel (out_valid / out_stall) returns one pcm_out per request,
//   in order.
//   The request lands in the input register at acceptance, and the
//   shaping, dither, clip and floor logic loads the result register when
//   the result register is free to take it (out_valid low or out_stall
//   low), raising out_valid. Throughput is one sample per cycle while the
//   receiver does not stall; the error feedback and the generator step are
//   updated as each sample advances, the generator multiply running one
//   value ahead in its own register.
//   When the receiver stalls, the result register holds; the input
//   register keeps accepting until it is also full, then in_stall rises.
//   Asynchronous reset (arst_n low) empties both registers, zeroes the
//   shaping errors and restarts the generator from zero.

module noise_shaped_dither_requantizer #(
	parameter int FRACTION_BITS = 28,
	parameter int OUTPUT_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nsdr_pkg::sample_t  sample,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output nsdr_pkg::pcm_t     pcm_out
);

	import nsdr_pkg::*;

	localparam int SCALE_RAW = FRACTION_BITS + 1 - OUTPUT_BITS;
	localparam int SCALE     = (SCALE_RAW < 1) ? 1 : SCALE_RAW;

	localparam acc_t        ONE      = acc_t'(1) <<< FRACTION_BITS;
	localparam acc_t        HI       = ONE - acc_t'(1);
	localparam acc_t        LO       = -ONE;
	localparam acc_t        BIAS     = acc_t'(1) <<< (SCALE - 1);
	localparam logic [31:0] LOW_MASK = (32'd1 << SCALE) - 32'd1;
	localparam acc_t        FLOOR_M  = ~((acc_t'(1) <<< SCALE) - acc_t'(1));

	logic        valid_s1;
	sample_t     sample_s1;
	logic        frame_start_s1;

	logic        out_valid_q;
	pcm_t        pcm_q;

	err_t        e0_q, e1_q, e2_q;
	logic [31:0] gen_q, next_q;

	logic        out_ready;
	logic        advance;

	err_t        e0_eff, e1_eff, e2_eff;
	logic [31:0] gen_eff, next_eff;
	logic [31:0] lcg_step;
	acc_t        x_ext, v, acc_pre, acc_c, v_c, acc_f, err_full, pcm_full;
	acc_t        dith_new, dith_old;
	logic [ERR_W:0] half_tmp;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign out_valid = out_valid_q;
	assign pcm_out   = pcm_q;

	always_comb begin
		if (frame_start_s1) begin
			e0_eff   = '0;
			e1_eff   = '0;
			e2_eff   = '0;
			gen_eff  = '0;
			next_eff = LCG_ADD;
		end else begin
			e0_eff   = e0_q;
			e1_eff   = e1_q;
			e2_eff   = e2_q;
			gen_eff  = gen_q;
			next_eff = next_q;
		end

		x_ext = {{(ACC_W-SAMPLE_W){sample_s1[SAMPLE_W-1]}}, sample_s1};
		v = x_ext + {{(ACC_W-ERR_W){e0_eff[ERR_W-1]}}, e0_eff}
			- {{(ACC_W-ERR_W){e1_eff[ERR_W-1]}}, e1_eff}
			+ {{(ACC_W-ERR_W){e2_eff[ERR_W-1]}}, e2_eff};

		dith_new = {{(ACC_W-32){1'b0}}, next_eff & LOW_MASK};
		dith_old = {{(ACC_W-32){1'b0}}, gen_eff & LOW_MASK};
		acc_pre  = v + BIAS + dith_new - dith_old;

		v_c = v;
		if (acc_pre > HI) begin
			acc_c = HI;
			if (v > HI) v_c = HI;
		end else if (acc_pre < LO) begin
			acc_c = LO;
			if (v < LO) v_c = LO;
		end else begin
			acc_c = acc_pre;
		end

		acc_f    = acc_c & FLOOR_M;
		err_full = v_c - acc_f;
		pcm_full = acc_f >>> SCALE;

		// halve toward zero
		half_tmp = {e0_eff[ERR_W-1], e0_eff} + {{ERR_W{1'b0}}, e0_eff[ERR_W-1]};

		lcg_step = 32'(next_eff * LCG_MUL + LCG_ADD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1      <= sample;
			frame_start_s1 <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pcm_q <= pcm_full[PCM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_q   <= '0;
			e1_q   <= '0;
			e2_q   <= '0;
			gen_q  <= '0;
			next_q <= LCG_ADD;
		end else if (advance) begin
			e0_q   <= err_full[ERR_W-1:0];
			e1_q   <= half_tmp[ERR_W:1];
			e2_q   <= e1_eff;
			gen_q  <= next_eff;
			next_q <= lcg_step;
		end
	end

endmodule

@@ rtl/nsdr_checker.sv @@
// Port-level checker for the requantizer, with its bind.
`timescale 1ns / 1ps
`include "noise_shaped_dither_requantizer_defines.svh"

module nsdr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input nsdr_pkg::sample_t sample,
	input logic              frame_start,
	input logic              out_valid,
	input logic              out_stall,
	input nsdr_pkg::pcm_t    pcm_out
);

	import nsdr_pkg::*;

	pcm_t pcm_seen;
	assign pcm_seen = pcm_out;

	// back-pressure only passes through a full, stalled result register
	`NSDR_ASSERT(a_stall_src, clk, arst_n, !in_stall || (out_valid && out_stall), "in_stall without output stall")

	// a stalled result holds
	`NSDR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pcm_seen), "stalled result changed")

	// an accepted request moves from the input register to the output when the path is open
	`NSDR_ASSERT_NEXT(a_latency, clk, arst_n, $past(in_valid && !in_stall) && (!out_valid || !out_stall), out_valid, "request did not reach output")

endmodule

bind noise_shaped_dither_requantizer nsdr_checker u_nsdr_checker (.*);

@@ bench/noise_shaped_dither_requantizer_test.sv @@
// Testbench for the noise-shaped dither requantizer: queued driver, output monitor, predictor.
`timescale 1ns / 1ps

module noise_shaped_dither_requantizer_test;
	import nsdr_pkg::*;

	localparam int FRAC_BITS = 28;
	localparam int PCM_BITS = 16;
	localparam int STEP_SHIFT = (FRAC_BITS + 1 - PCM_BITS < 1) ? 1 : FRAC_BITS + 1 - PCM_BITS;
	localparam longint FULL_SCALE = longint'(1) << FRAC_BITS;
	localparam longint STEP_MASK = (longint'(1) << STEP_SHIFT) - 1;
	localparam logic [31:0] DITHER_MASK = (32'd1 << STEP_SHIFT) - 1;
	localparam int RANDOM_REQS = 1200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 11;

	typedef struct {
		sample_t value;
		logic    frame;
		logic    drain_first;
	} audio_req_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	sample_t sample;
	logic    frame_start;
	logic    out_valid;
	logic    out_stall;
	pcm_t    pcm_out;

	audio_req_t pending_reqs[$];
	pcm_t       pcm_expected[$];
	err_t       err_new, err_half, err_old;
	logic [31:0] lcg_state;
	logic       in_busy;
	int         n_accepted;
	int         n_cycles;
	int         failures;
	logic       calm;

	noise_shaped_dither_requantizer #(
		.FRACTION_BITS(FRAC_BITS),
		.OUTPUT_BITS(PCM_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pcm_out(pcm_out)
	);

	function automatic pcm_t requantize(sample_t x, logic frame);
		longint shaped;
		longint acc;
		logic [31:0] lcg_next;
		if (frame) begin
			err_new = '0;
			err_half = '0;
			err_old = '0;
			lcg_state = '0;
		end
		shaped = longint'(x) + longint'(err_new) - longint'(err_half) + longint'(err_old);
		err_old = err_half;
		err_half = err_new / 2;
		acc = shaped + (longint'(1) << (STEP_SHIFT - 1));
		lcg_next = lcg_state * LCG_MUL + LCG_ADD;
		acc = acc + longint'(lcg_next & DITHER_MASK) - longint'(lcg_state & DITHER_MASK);
		lcg_state = lcg_next;
		if (acc > FULL_SCALE - 1) begin
			acc = FULL_SCALE - 1;
			if (shaped > FULL_SCALE - 1)
				shaped = FULL_SCALE - 1;
		end else if (acc < -FULL_SCALE) begin
			acc = -FULL_SCALE;
			if (shaped < -FULL_SCALE)
				shaped = -FULL_SCALE;
		end
		acc = ((acc + FULL_SCALE) & ~STEP_MASK) - FULL_SCALE;
		err_new = err_t'(shaped - acc);
		return pcm_t'(((acc + FULL_SCALE) >> STEP_SHIFT)
			- (longint'(1) << (FRAC_BITS - STEP_SHIFT)));
	endfunction

	task automatic queue_sample(longint value, logic frame, logic drain_first);
		audio_req_t r;
		r.value = sample_t'(value);
		r.frame = frame;
		r.drain_first = drain_first;
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	assign calm = (n_accepted >= 400) && (n_accepted < 700);

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
			if (!in_busy) begin
				if (pending_reqs.size() != 0
					&& !(pending_reqs[0].drain_first && pcm_expected.size() != 0)
					&& (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					sample <= pending_reqs[0].value;
					frame_start <= pending_reqs[0].frame;
					in_busy = 1'b1;
				end else begin
					in_valid <= 1'b0;
					sample <= $urandom;
					frame_start <= 1'($urandom_range(0, 1));
				end
			end
		end
	end

	// accepted requests feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pcm_expected.push_back(requantize(sample, frame_start));
			void'(pending_reqs.pop_front());
			in_busy = 1'b0;
			n_accepted++;
		end
	end

	// result monitor and cycle limit
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pcm_expected.size() == 0) begin
				$error("pcm_out unexpected: expected none, actual %0d", pcm_out);
				failures++;
			end else begin
				if (pcm_out !== pcm_expected[0]) begin
					$error("pcm_out mismatch: expected %0d, actual %0d",
						pcm_expected[0], pcm_out);
					failures++;
				end
				void'(pcm_expected.pop_front());
			end
		end
	end

	initial begin
		int n_random;
		int frame_len;
		int kind;
		longint value;
		logic drain_mark;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		sample = '0;
		frame_start = 1'b0;
		in_busy = 1'b0;
		n_accepted = 0;
		n_cycles = 0;
		failures = 0;
		err_new = '0;
		err_half = '0;
		err_old = '0;
		lcg_state = '0;

		// directed: full-scale edges, clipping, out-of-range inputs, frame restarts
		queue_sample(0, 1'b1, 1'b0);
		queue_sample(FULL_SCALE - 1, 1'b0, 1'b0);
		queue_sample(FULL_SCALE - 1, 1'b0, 1'b0);
		queue_sample(FULL_SCALE - 1, 1'b0, 1'b0);
		queue_sample(-FULL_SCALE, 1'b0, 1'b0);
		queue_sample(-FULL_SCALE, 1'b0, 1'b0);
		queue_sample(32'h7fff_ffff, 1'b0, 1'b0);
		queue_sample(-longint'(32'h8000_0000), 1'b0, 1'b0);
		queue_sample(FULL_SCALE + 1, 1'b0, 1'b0);
		queue_sample(-FULL_SCALE - 1, 1'b0, 1'b0);
		queue_sample(1, 1'b1, 1'b0);
		queue_sample(-1, 1'b0, 1'b0);
		queue_sample(FULL_SCALE / 2, 1'b0, 1'b0);
		queue_sample(-FULL_SCALE / 2, 1'b0, 1'b0);
		queue_sample(longint'(1) << (STEP_SHIFT - 1), 1'b0, 1'b0);
		queue_sample(-(longint'(1) << (STEP_SHIFT - 1)), 1'b0, 1'b0);
		queue_sample(STEP_MASK, 1'b0, 1'b0);
		queue_sample(32'h7fff_ffff, 1'b1, 1'b0);
		queue_sample(-longint'(32'h8000_0000), 1'b1, 1'b0);
		queue_sample(0, 1'b0, 1'b0);
		queue_sample(0, 1'b0, 1'b1);

		// random frames: mostly in-range audio, some near full scale, some raw noise
		n_random = 0;
		drain_mark = 1'b0;
		while (n_random < RANDOM_REQS) begin
			frame_len = $urandom_range(1, 40);
			for (int i = 0; i < frame_len; i++) begin
				kind = $urandom_range(0, 99);
				if (kind < 70)
					value = longint'($urandom_range(0, 32'h1fff_ffff)) - FULL_SCALE;
				else if (kind < 85)
					value = ($urandom_range(0, 1) ? FULL_SCALE : -FULL_SCALE)
						+ longint'($urandom_range(0, 40000)) - 20000;
				else
					value = longint'(sample_t'($urandom));
				queue_sample(value, (i == 0) || ($urandom_range(0, 99) < 3),
					!drain_mark && n_random >= RANDOM_REQS / 2);
				if (n_random >= RANDOM_REQS / 2)
					drain_mark = 1'b1;
				n_random++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || pcm_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0 && pcm_expected.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (pcm_expected.size() != 0)
				$error("pcm_out missing: expected %0d more, actual 0", pcm_expected.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ noise_shaped_dither_requantizer.f @@
+incdir+rtl
rtl/nsdr_pkg.sv
rtl/noise_shaped_dither_requantizer.sv
rtl/nsdr_checker.sv
bench/noise_shaped_dither_requantizer_test.sv
